FILE: rtl/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types and constants for the peer MAC table: operation codes, entry
// layout and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pmt_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;

   localparam int OP_W   = 3;
   localparam int MAC_W  = 48;
   localparam int IDX_W  = 4;
   localparam int FC_W   = 8;
   localparam int LEN_W  = 12;
   localparam int RSSI_W = 8;
   localparam int CNT_W  = 5;

   localparam logic [FC_W-1:0]         ACTION_FC     = 8'hD0;
   localparam logic [LEN_W-1:0]        ADDR2_OFFSET  = 12'd10;
   localparam logic [LEN_W-1:0]        MIN_FRAME_LEN = ADDR2_OFFSET + 12'd6;
   localparam logic signed [RSSI_W-1:0] NO_RSSI      = -8'sd128;

   typedef enum logic [OP_W-1:0] {
      OP_ADD          = 3'd0,
      OP_REMOVE_MAC   = 3'd1,
      OP_REMOVE_INDEX = 3'd2,
      OP_LOOKUP       = 3'd3,
      OP_OBSERVE      = 3'd4,
      OP_CLEAR        = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      WALK_FROM_ZERO,
      WALK_FROM_HIT,
      WALK_FROM_INDEX
   } walk_from_type;

   typedef struct packed {
      logic [MAC_W-1:0]         mac;
      logic signed [RSSI_W-1:0] rssi;
   } entry_type;

   typedef struct packed {
      logic          load;
      logic          walk_start;
      walk_from_type walk_from;
      logic          walk_step;
      logic          shift_wr;
      logic          hit_capture;
      logic          rssi_from_frame;
      logic          obs_write;
      logic          append;
      logic          set_ok;
      logic          count_clear;
      logic          count_inc;
      logic          count_dec;
      logic          rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   frame_ok;
      logic   index_ok;
      logic   hit;
      logic   walk_end;
      logic   rsp_free;
   } status_type;

endpackage

FILE: rtl/pmt_ram.sv
// ----------------------------------------------------------------------------
// pmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/pmt_dpath.sv
// ----------------------------------------------------------------------------
// pmt_dpath
// Datapath of the peer MAC table: request and result registers, entry RAM,
// walk pointer for search and compaction, entry count and output register.
// ----------------------------------------------------------------------------
module pmt_dpath #(
   parameter int TABLE_ENTRIES = pmt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pmt_pkg::cmd_type                     cmd,
   output pmt_pkg::status_type                  status,
   input  logic [pmt_pkg::OP_W-1:0]             req_operation,
   input  logic [pmt_pkg::MAC_W-1:0]            req_mac,
   input  logic [pmt_pkg::IDX_W-1:0]            req_index,
   input  logic                                 req_frame_is_management,
   input  logic [pmt_pkg::FC_W-1:0]             req_frame_control,
   input  logic [pmt_pkg::LEN_W-1:0]            req_frame_length,
   input  logic signed [pmt_pkg::RSSI_W-1:0]    req_frame_rssi,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_ok,
   output logic                                 rsp_found,
   output logic [pmt_pkg::IDX_W-1:0]            rsp_match_index,
   output logic signed [pmt_pkg::RSSI_W-1:0]    rsp_stored_rssi,
   output logic [pmt_pkg::CNT_W-1:0]            rsp_entry_count
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int XW = ((CW > pmt_pkg::IDX_W) ? CW : pmt_pkg::IDX_W) + 1;
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

   // request registers
   pmt_pkg::op_type                   op_ff;
   logic [pmt_pkg::MAC_W-1:0]         mac_ff;
   logic [pmt_pkg::IDX_W-1:0]         idx_ff;
   logic                              frame_ok_ff;
   logic signed [pmt_pkg::RSSI_W-1:0] frssi_ff;

   // table control
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] cur_ff, cur_in;

   // working result
   logic                              res_ok_ff, res_ok_in;
   logic                              res_found_ff, res_found_in;
   logic [pmt_pkg::IDX_W-1:0]         res_idx_ff, res_idx_in;
   logic signed [pmt_pkg::RSSI_W-1:0] res_rssi_ff, res_rssi_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_ok_ff;
   logic                              rsp_found_ff;
   logic [pmt_pkg::IDX_W-1:0]         rsp_idx_ff;
   logic signed [pmt_pkg::RSSI_W-1:0] rsp_rssi_ff;
   logic [pmt_pkg::CNT_W-1:0]         rsp_count_ff;

   // RAM ports
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   pmt_pkg::entry_type    wr_entry;
   pmt_pkg::entry_type    rd_entry;
   logic [$bits(pmt_pkg::entry_type)-1:0] rd_raw;

   logic [XW-1:0] idx_ext;
   logic [XW-1:0] count_ext;

   pmt_ram #(
      .WIDTH ($bits(pmt_pkg::entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   assign rd_entry  = pmt_pkg::entry_type'(rd_raw);
   assign idx_ext   = XW'(idx_ff);
   assign count_ext = XW'(count_ff);

   always_comb begin
      status.op       = op_ff;
      status.full     = (count_ff == FULL_COUNT);
      status.frame_ok = frame_ok_ff;
      status.index_ok = (idx_ext < count_ext);
      status.hit      = pend_ff && (rd_entry.mac == mac_ff);
      status.walk_end = !pend_ff && (rd_ptr_ff >= count_ff);
      status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   // walk pointer: one read issued per step, data compared or moved in the next cycle
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      pend_in   = pend_ff;
      cur_in    = cur_ff;
      if (cmd.walk_start) begin
         pend_in = 1'b0;
         case (cmd.walk_from)
            pmt_pkg::WALK_FROM_HIT:   rd_ptr_in = CW'(cur_ff) + CW'(1);
            pmt_pkg::WALK_FROM_INDEX: rd_ptr_in = CW'(idx_ext + XW'(1));
            default:                  rd_ptr_in = '0;
         endcase
      end else if (cmd.walk_step) begin
         if (rd_ptr_ff < count_ff) begin
            pend_in   = 1'b1;
            cur_in    = rd_ptr_ff[AW-1:0];
            rd_ptr_in = rd_ptr_ff + CW'(1);
         end else begin
            pend_in = 1'b0;
         end
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = cur_ff;
      wr_entry = rd_entry;
      if (cmd.append) begin
         wr_en         = 1'b1;
         wr_addr       = count_ff[AW-1:0];
         wr_entry.mac  = mac_ff;
         wr_entry.rssi = '0;
      end else if (cmd.obs_write) begin
         wr_en         = 1'b1;
         wr_entry.mac  = mac_ff;
         wr_entry.rssi = frssi_ff;
      end else if (cmd.shift_wr && pend_ff) begin
         // move the entry one place down
         wr_en   = 1'b1;
         wr_addr = cur_ff - AW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      res_ok_in    = res_ok_ff;
      res_found_in = res_found_ff;
      res_idx_in   = res_idx_ff;
      res_rssi_in  = res_rssi_ff;
      if (cmd.load) begin
         res_ok_in    = 1'b0;
         res_found_in = 1'b0;
         res_idx_in   = '0;
         res_rssi_in  = pmt_pkg::NO_RSSI;
      end
      if (cmd.hit_capture) begin
         res_found_in = 1'b1;
         res_idx_in   = pmt_pkg::IDX_W'(cur_ff);
         res_rssi_in  = cmd.rssi_from_frame ? frssi_ff : rd_entry.rssi;
      end
      if (cmd.set_ok) begin
         res_ok_in = 1'b1;
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      cur_ff       <= cur_in;
      res_ok_ff    <= res_ok_in;
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      res_rssi_ff  <= res_rssi_in;
      if (cmd.load) begin
         op_ff       <= pmt_pkg::op_type'(req_operation);
         mac_ff      <= req_mac;
         idx_ff      <= req_index;
         frssi_ff    <= req_frame_rssi;
         frame_ok_ff <= req_frame_is_management
                        && (req_frame_control == pmt_pkg::ACTION_FC)
                        && (req_frame_length >= pmt_pkg::MIN_FRAME_LEN);
      end
      if (cmd.rsp_load) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_found_ff <= res_found_ff;
         rsp_idx_ff   <= res_idx_ff;
         rsp_rssi_ff  <= res_rssi_ff;
         rsp_count_ff <= pmt_pkg::CNT_W'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_idx_ff;
   assign rsp_stored_rssi = rsp_rssi_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: rtl/pmt_ctrl.sv
// ----------------------------------------------------------------------------
// pmt_ctrl
// Controller of the peer MAC table: sequences decode, search walk,
// compaction walk and result hand-off for one item at a time.
// ----------------------------------------------------------------------------
module pmt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pmt_pkg::status_type status,
   output pmt_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FINISH;
            case (status.op)
               pmt_pkg::OP_ADD: begin
                  if (!status.full) begin
                     cmd.walk_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               pmt_pkg::OP_REMOVE_MAC, pmt_pkg::OP_LOOKUP: begin
                  cmd.walk_start = 1'b1;
                  state_in       = ST_SCAN;
               end
               pmt_pkg::OP_OBSERVE: begin
                  if (status.frame_ok) begin
                     cmd.walk_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               pmt_pkg::OP_REMOVE_INDEX: begin
                  if (status.index_ok) begin
                     cmd.set_ok     = 1'b1;
                     cmd.walk_start = 1'b1;
                     cmd.walk_from  = pmt_pkg::WALK_FROM_INDEX;
                     state_in       = ST_SHIFT;
                  end
               end
               pmt_pkg::OP_CLEAR: begin
                  cmd.count_clear = 1'b1;
                  cmd.set_ok      = 1'b1;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_SCAN: begin
            if (status.hit) begin
               cmd.hit_capture = 1'b1;
               state_in        = ST_FINISH;
               case (status.op)
                  pmt_pkg::OP_REMOVE_MAC: begin
                     cmd.set_ok     = 1'b1;
                     cmd.walk_start = 1'b1;
                     cmd.walk_from  = pmt_pkg::WALK_FROM_HIT;
                     state_in       = ST_SHIFT;
                  end
                  pmt_pkg::OP_LOOKUP: begin
                     cmd.set_ok = 1'b1;
                  end
                  pmt_pkg::OP_OBSERVE: begin
                     cmd.rssi_from_frame = 1'b1;
                     cmd.obs_write       = 1'b1;
                     cmd.set_ok          = 1'b1;
                  end
                  default: begin
                     // duplicate on add: report it, change nothing
                     cmd.set_ok = 1'b0;
                  end
               endcase
            end else if (status.walk_end) begin
               state_in = ST_FINISH;
               if (status.op == pmt_pkg::OP_ADD) begin
                  cmd.append    = 1'b1;
                  cmd.count_inc = 1'b1;
                  cmd.set_ok    = 1'b1;
               end
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_SHIFT: begin
            if (status.walk_end) begin
               cmd.count_dec = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.walk_step = 1'b1;
               cmd.shift_wr  = 1'b1;
            end
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/peer_mac_table_with_rssi.sv
// ----------------------------------------------------------------------------
// peer_mac_table_with_rssi
// Compacted table of peer MAC addresses with last-seen RSSI per entry.
// ----------------------------------------------------------------------------
// One item is handled at a time. Entries sit in a single RAM with one read
// and one write port, and every search or compaction walks it one entry per
// cycle. A search (lookup, add, observe, remove by MAC) compares the stored
// entries in order until a match or the last entry. Remove by MAC then moves
// every entry after the removed one down one place, and remove by index does
// the same after the given index. Clear or a rejected item walks no entry.
// A finished result waits in the output register while the next item is
// already accepted. No clearing pass follows reset: the table starts empty.
module peer_mac_table_with_rssi #(
   parameter int TABLE_ENTRIES = pmt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pmt_pkg::OP_W-1:0]          req_operation,
   input  logic [pmt_pkg::MAC_W-1:0]         req_mac,
   input  logic [pmt_pkg::IDX_W-1:0]         req_index,
   input  logic                              req_frame_is_management,
   input  logic [pmt_pkg::FC_W-1:0]          req_frame_control,
   input  logic [pmt_pkg::LEN_W-1:0]         req_frame_length,
   input  logic signed [pmt_pkg::RSSI_W-1:0] req_frame_rssi,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic                              rsp_found,
   output logic [pmt_pkg::IDX_W-1:0]         rsp_match_index,
   output logic signed [pmt_pkg::RSSI_W-1:0] rsp_stored_rssi,
   output logic [pmt_pkg::CNT_W-1:0]         rsp_entry_count
);

   pmt_pkg::cmd_type    cmd;
   pmt_pkg::status_type status;

   pmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pmt_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_operation           (req_operation),
      .req_mac                 (req_mac),
      .req_index               (req_index),
      .req_frame_is_management (req_frame_is_management),
      .req_frame_control       (req_frame_control),
      .req_frame_length        (req_frame_length),
      .req_frame_rssi          (req_frame_rssi),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_ok                  (rsp_ok),
      .rsp_found               (rsp_found),
      .rsp_match_index         (rsp_match_index),
      .rsp_stored_rssi         (rsp_stored_rssi),
      .rsp_entry_count         (rsp_entry_count)
   );

   a_no_add_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> !status.full)
      else $error("entry count raised on a full table");

   a_capture_on_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.hit_capture |-> status.hit)
      else $error("match captured without a hit");

   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.append, cmd.obs_write, cmd.shift_wr}))
      else $error("more than one table write source active");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new item accepted while one is in work");

endmodule
